// ----- sv/pcems_pkg.sv -----
// Shared types, constants and reset values for the chipset register and decode block.
`timescale 1ns / 1ps

package pcems_pkg;

  localparam int PAGE_COUNT = 4;
  localparam int REG_COUNT  = 32;
  localparam int REG_AW     = $clog2(REG_COUNT);
  localparam int PAGE_AW    = $clog2(PAGE_COUNT);
  localparam int ADDR_W     = 24;
  localparam int RAMKB_W    = 15;

  // Word kinds
  localparam logic [1:0] KIND_PORT_RD = 2'd0;
  localparam logic [1:0] KIND_PORT_WR = 2'd1;
  localparam logic [1:0] KIND_DECODE  = 2'd2;

  // Routes
  localparam logic [1:0] ROUTE_DRAM = 2'd0;
  localparam logic [1:0] ROUTE_BUS  = 2'd1;
  localparam logic [1:0] ROUTE_ANY  = 2'd2;
  localparam logic [1:0] ROUTE_NONE = 2'd3;

  // Register index codes seen through the index port
  localparam logic [7:0] IDX_FIRST     = 8'h20;
  localparam logic [7:0] IDX_EMS_FIRST = 8'h24;
  localparam logic [7:0] IDX_EMS_LAST  = 8'h2b;
  localparam logic [7:0] IDX_PLAIN_END = 8'h2d;
  localparam logic [7:0] IDX_FORCE4    = 8'h2e;
  localparam logic [7:0] IDX_A20       = 8'h31;
  localparam logic [7:0] IDX_HI_FIRST  = 8'h32;
  localparam logic [7:0] IDX_LAST      = 8'h3f;

  // Register file rows with a fixed meaning
  localparam logic [REG_AW-1:0] ROW_EXT_FE = REG_AW'(5'h00);
  localparam logic [REG_AW-1:0] ROW_SHADOW = REG_AW'(5'h02);
  localparam logic [REG_AW-1:0] ROW_CTRL   = REG_AW'(5'h03);
  localparam logic [REG_AW-1:0] ROW_EXTC_D = REG_AW'(5'h07);
  localparam logic [REG_AW-1:0] ROW_WIN    = REG_AW'(5'h0c);
  localparam logic [REG_AW-1:0] ROW_SELC_D = REG_AW'(5'h0d);
  localparam logic [REG_AW-1:0] ROW_EMS0   = REG_AW'(5'h04);

  // Address map
  localparam logic [ADDR_W-1:0] ADDR_LOW_BASE = 24'h0a0000;
  localparam logic [ADDR_W-1:0] ADDR_LOW_TOP  = 24'h0fffff;
  localparam logic [ADDR_W-1:0] ADDR_SHD_BASE = 24'h0c0000;
  localparam logic [ADDR_W-1:0] ADDR_EXT_BASE = 24'hf80000;
  localparam logic [ADDR_W-1:0] ADDR_FE_BASE  = 24'hfe0000;
  localparam logic [ADDR_W-1:0] ADDR_FE_TOP   = 24'hfeffff;
  localparam logic [ADDR_W-1:0] WIN_SPAN      = 24'h010000;
  localparam int                PAGE_SHIFT    = 14;
  localparam logic [7:0]        EXT_TOP_SEG   = 8'hfe;

  localparam logic [ADDR_W-1:0] WIN_BASES [4] = '{
    24'h0c0000, 24'h0c8000, 24'h0d0000, 24'h0e0000
  };

  localparam logic [8:0] REMAP_NONE = 9'd0;
  localparam logic [8:0] REMAP_128  = 9'd128;
  localparam logic [8:0] REMAP_256  = 9'd256;
  localparam logic [8:0] REMAP_384  = 9'd384;

  localparam logic [RAMKB_W-1:0] RAM_KB_RESET = 15'd1024;
  localparam logic [7:0]         BYTE_FF      = 8'hff;
  localparam logic [7:0]         FORCE_BIT4   = 8'h10;

  typedef struct packed {
    logic [1:0]        kind;
    logic              port_odd;
    logic [7:0]        io_data;
    logic [ADDR_W-1:0] mem_addr;
    logic              mem_is_write;
  } req_t;

  typedef struct packed {
    logic [7:0]        read_data;
    logic [1:0]        route;
    logic [ADDR_W-1:0] phys_addr;
    logic              beyond_ram;
    logic              a20_alt;
    logic              reset_pulse;
    logic [8:0]        remap_kb;
  } rsp_t;

  // Register file contents after reset
  function automatic logic [7:0] reg_reset(input logic [REG_AW-1:0] row);
    logic [7:0] v;
    case (row)
      5'h00:   v = 8'h02;
      5'h0e:   v = 8'h10;
      5'h11:   v = 8'h01;
      5'h13:   v = 8'h40;
      5'h15:   v = 8'h40;
      5'h17:   v = 8'h40;
      5'h19:   v = 8'h40;
      5'h1b:   v = 8'h40;
      5'h1c:   v = 8'h22;
      5'h1d:   v = 8'hc4;
      5'h1f:   v = 8'h30;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

// ----- sv/pcems_if.sv -----
// Valid/ready channel interfaces for request, response and configuration words.
`timescale 1ns / 1ps

interface pcems_req_if;
  import pcems_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        kind;
  logic              port_odd;
  logic [7:0]        io_data;
  logic [ADDR_W-1:0] mem_addr;
  logic              mem_is_write;

  modport source (output valid, kind, port_odd, io_data, mem_addr, mem_is_write,
                  input ready);
  modport sink   (input valid, kind, port_odd, io_data, mem_addr, mem_is_write,
                  output ready);
endinterface

interface pcems_rsp_if;
  import pcems_pkg::*;
  logic              valid;
  logic              ready;
  logic [7:0]        read_data;
  logic [1:0]        route;
  logic [ADDR_W-1:0] phys_addr;
  logic              beyond_ram;
  logic              a20_alt;
  logic              reset_pulse;
  logic [8:0]        remap_kb;

  modport source (output valid, read_data, route, phys_addr, beyond_ram, a20_alt,
                  reset_pulse, remap_kb, input ready);
  modport sink   (input valid, read_data, route, phys_addr, beyond_ram, a20_alt,
                  reset_pulse, remap_kb, output ready);
endinterface

interface pcems_cfg_if;
  import pcems_pkg::*;
  logic               valid;
  logic               ready;
  logic [RAMKB_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ----- sv/pc_chipset_ems_shadow_decoder.sv -----
// Top level: index/data register block, EMS translator and memory route decoder.
`timescale 1ns / 1ps

// Takes one word per clock on req while the skid is empty and returns exactly
// one word on rsp for it. Register updates and the address decode are done in
// the accept cycle by a single layer of logic feeding the response register,
// or the skid when rsp stalls; the sustained rate is one word per clock while
// rsp does not stall. A two-entry output buffer (response register plus skid)
// keeps req ready after rsp stalls until the skid is full. The cfg port loads
// the installed RAM size in KB and is ready whenever reset is low; write it
// only while no word is in flight. Neither req nor cfg is ready during reset.
module pc_chipset_ems_shadow_decoder
  import pcems_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  pcems_req_if.sink   req,
  pcems_rsp_if.source rsp,
  pcems_cfg_if.sink   cfg
);

  // Architectural state
  logic [RAMKB_W-1:0]    ram_size_kb;
  logic [7:0]            index_reg;
  logic [7:0]            reg_file [REG_COUNT];
  logic [PAGE_COUNT-1:0] ems_written;
  logic                  a20_flag;

  logic [7:0]            index_reg_next;
  logic [7:0]            reg_file_next [REG_COUNT];
  logic [PAGE_COUNT-1:0] ems_written_next;
  logic                  a20_flag_next;

  // Output buffer
  logic out_valid, skid_valid;
  rsp_t out_word, skid_word;

  req_t        rq;
  rsp_t        res;
  logic        in_fire, pop;
  logic [REG_AW-1:0] row;
  logic        pulse;
  logic [7:0]  rd_data;

  assign rq = '{kind: req.kind, port_odd: req.port_odd, io_data: req.io_data,
                mem_addr: req.mem_addr, mem_is_write: req.mem_is_write};
  assign req.ready = !rst && !skid_valid;
  assign in_fire   = req.valid && req.ready;
  assign pop       = out_valid && rsp.ready;
  assign cfg.ready = !rst;
  assign row       = index_reg[REG_AW-1:0];

  // Port access: index load, register read and write
  always_comb begin
    logic [2:0] pg_tmp;
    index_reg_next   = index_reg;
    reg_file_next    = reg_file;
    ems_written_next = ems_written;
    a20_flag_next    = a20_flag;
    pulse            = 1'b0;
    rd_data          = 8'h00;
    pg_tmp           = row[3:1] - 3'd2;
    case (rq.kind)
      KIND_PORT_RD: begin
        if (!rq.port_odd) begin
          rd_data = index_reg;
        end else if ((index_reg >= IDX_FIRST && index_reg <= IDX_FORCE4) ||
                     (index_reg >= IDX_A20 && index_reg <= IDX_LAST)) begin
          rd_data = reg_file[row];
        end else begin
          rd_data = BYTE_FF;
        end
      end
      KIND_PORT_WR: begin
        if (!rq.port_odd) begin
          index_reg_next = rq.io_data;
        end else if (index_reg >= IDX_FIRST && index_reg <= IDX_PLAIN_END) begin
          reg_file_next[row] = rq.io_data;
          if (index_reg >= IDX_EMS_FIRST && index_reg <= IDX_EMS_LAST) begin
            ems_written_next[pg_tmp[PAGE_AW-1:0]] = 1'b1;
          end
        end else if (index_reg == IDX_FORCE4) begin
          reg_file_next[row] = rq.io_data | FORCE_BIT4;
        end else if (index_reg == IDX_A20) begin
          reg_file_next[row] = rq.io_data;
          a20_flag_next      = rq.io_data[0];
          pulse              = rq.io_data[1];
        end else if (index_reg >= IDX_HI_FIRST && index_reg <= IDX_LAST) begin
          reg_file_next[row] = rq.io_data;
        end
      end
      default: ;
    endcase
  end

  // EMS page bases: reset layout until either register of a page's pair is written
  logic [ADDR_W-1:0] page_base [PAGE_COUNT];
  always_comb begin
    for (int k = 0; k < PAGE_COUNT; k++) begin
      if (ems_written[k]) begin
        page_base[k] = {reg_file[ROW_EMS0 + REG_AW'(2 * k)][4:0],
                        reg_file[ROW_EMS0 + REG_AW'(2 * k + 1)][4:0],
                        {PAGE_SHIFT{1'b0}}};
      end else begin
        page_base[k] = ADDR_W'(k) << PAGE_SHIFT;
      end
    end
  end

  // Memory decode
  logic [7:0]        r_shd, r_ctl, r_extcd, r_win, r_selcd, r_fe;
  logic [ADDR_W-1:0] addr, win_base, win_off;
  logic              in_low, in_win, in_fe, in_ext;
  logic [1:0]        dec_route, shd_route, shd_ext;
  logic [ADDR_W-1:0] dec_phys;
  logic              shd_sel, shd_en;
  logic [7:0]        ext_reg;
  logic [2:0]        ext_row;

  assign r_fe    = reg_file[ROW_EXT_FE];
  assign r_shd   = reg_file[ROW_SHADOW];
  assign r_ctl   = reg_file[ROW_CTRL];
  assign r_extcd = reg_file[ROW_EXTC_D];
  assign r_win   = reg_file[ROW_WIN];
  assign r_selcd = reg_file[ROW_SELC_D];
  assign addr    = rq.mem_addr;

  assign win_base = WIN_BASES[r_win[1:0]];
  assign win_off  = addr - win_base;
  assign in_low   = addr >= ADDR_LOW_BASE && addr <= ADDR_LOW_TOP;
  assign in_win   = r_ctl[3] && addr >= win_base && win_off < WIN_SPAN;
  assign in_fe    = addr >= ADDR_FE_BASE && addr <= ADDR_FE_TOP;
  assign in_ext   = addr >= ADDR_EXT_BASE && addr < ADDR_FE_BASE;

  // Shadow blocks C0000-FFFFF: addr[17] picks the upper half (E0000 and up)
  always_comb begin
    if (!addr[17]) begin
      shd_en  = rq.mem_is_write ? r_shd[3] : r_shd[2];
      shd_sel = r_selcd[addr[16:15]];
      shd_ext = (addr[16] ? r_extcd[7] : r_extcd[6]) ? ROUTE_ANY : ROUTE_BUS;
    end else begin
      shd_en  = rq.mem_is_write ? r_shd[1] : r_shd[0];
      shd_sel = r_win[{1'b1, addr[16]}];
      shd_ext = (addr[16] || r_win[4]) ? ROUTE_ANY : ROUTE_BUS;
    end
    shd_route = (shd_sel && shd_en) ? ROUTE_DRAM : shd_ext;
  end

  // F80000-FDFFFF: rows 6 down to 1, one bit per 32 KB half
  assign ext_row = 3'(EXT_TOP_SEG - addr[23:16]);
  always_comb begin
    case (ext_row)
      3'd1:    ext_reg = reg_file[1];
      3'd2:    ext_reg = reg_file[2];
      3'd3:    ext_reg = reg_file[3];
      3'd4:    ext_reg = reg_file[4];
      3'd5:    ext_reg = reg_file[5];
      default: ext_reg = reg_file[6];
    endcase
  end

  always_comb begin
    dec_route = ROUTE_NONE;
    dec_phys  = addr;
    if (in_low) begin
      if (in_win) begin
        dec_route = ROUTE_DRAM;
        dec_phys  = page_base[win_off[PAGE_SHIFT+PAGE_AW-1:PAGE_SHIFT]] +
                    {{(ADDR_W-PAGE_SHIFT){1'b0}}, addr[PAGE_SHIFT-1:0]};
      end else if (addr >= ADDR_SHD_BASE) begin
        dec_route = shd_route;
      end
    end else if (in_fe) begin
      dec_route = r_fe[6] ? ROUTE_ANY : ROUTE_DRAM;
    end else if (in_ext) begin
      dec_route = (addr[15] ? ext_reg[7] : ext_reg[6]) ? ROUTE_ANY : ROUTE_DRAM;
    end
  end

  // Response word
  logic [7:0] ctl_next, shd_next;
  logic [8:0] remap;
  assign ctl_next = reg_file_next[ROW_CTRL];
  assign shd_next = reg_file_next[ROW_SHADOW];
  always_comb begin
    if (!ctl_next[4])          remap = REMAP_NONE;
    else if (|shd_next[3:2])   remap = REMAP_128;
    else if (|shd_next[1:0])   remap = REMAP_256;
    else                       remap = REMAP_384;
  end

  always_comb begin
    res             = '0;
    res.route       = ROUTE_NONE;
    res.read_data   = rd_data;
    res.a20_alt     = a20_flag_next;
    res.reset_pulse = pulse;
    res.remap_kb    = remap;
    if (rq.kind == KIND_DECODE) begin
      res.route      = dec_route;
      res.phys_addr  = dec_phys;
      res.beyond_ram = dec_route == ROUTE_DRAM &&
                       {1'b0, dec_phys} >= {ram_size_kb, 10'b0};
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ram_size_kb <= RAM_KB_RESET;
      index_reg   <= '0;
      ems_written <= '0;
      a20_flag    <= 1'b1;
      for (int i = 0; i < REG_COUNT; i++) begin
        reg_file[i] <= reg_reset(REG_AW'(i));
      end
    end else begin
      if (cfg.valid) begin
        ram_size_kb <= cfg.data;
      end
      if (in_fire) begin
        index_reg   <= index_reg_next;
        reg_file    <= reg_file_next;
        ems_written <= ems_written_next;
        a20_flag    <= a20_flag_next;
      end
    end
  end

  // Output buffer: response register plus skid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (skid_valid) begin
        if (pop) begin
          out_word   <= skid_word;
          skid_valid <= 1'b0;
        end
      end else if (in_fire) begin
        if (!out_valid || pop) begin
          out_word  <= res;
          out_valid <= 1'b1;
        end else begin
          skid_word  <= res;
          skid_valid <= 1'b1;
        end
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.read_data   = out_word.read_data;
  assign rsp.route       = out_word.route;
  assign rsp.phys_addr   = out_word.phys_addr;
  assign rsp.beyond_ram  = out_word.beyond_ram;
  assign rsp.a20_alt     = out_word.a20_alt;
  assign rsp.reset_pulse = out_word.reset_pulse;
  assign rsp.remap_kb    = out_word.remap_kb;

  // Checks
  a_skid_has_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid word held without a response word");

  a_a20_after_rst: assert property (@(posedge clk)
    rst |=> a20_flag)
    else $error("A20 flag not set after reset");

  a_pulse_port_only: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.reset_pulse |-> out_word.route == ROUTE_NONE &&
    out_word.read_data == 8'h00)
    else $error("reset pulse on a word that is not a port write");

  a_beyond_dram: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.beyond_ram |-> out_word.route == ROUTE_DRAM)
    else $error("beyond_ram flagged on a non-DRAM route");

endmodule
